/* rtl/mii_prf_pkg.sv */
// Shared types, register map and default values for the MII PHY register file.
package mii_prf_pkg;

  // One command beat and one result beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  reg_addr;
    logic [15:0] write_data;
  } phy_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        speed_100;
    logic        duplex_full;
    logic        negotiated;
    logic        link_notify;
  } phy_result_t;

  // Command codes
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAUSE = 2'd0;
  localparam logic [1:0] CFG_DELAY = 2'd1;
  localparam logic [1:0] CFG_IDHI  = 2'd2;
  localparam logic [1:0] CFG_IDLO  = 2'd3;

  // Clause 22 register numbers
  localparam logic [4:0] R_BMCR   = 5'd0;
  localparam logic [4:0] R_BMSR   = 5'd1;
  localparam logic [4:0] R_ID2    = 5'd2;
  localparam logic [4:0] R_ID3    = 5'd3;
  localparam logic [4:0] R_ANAR   = 5'd4;
  localparam logic [4:0] R_ANLPAR = 5'd5;
  localparam logic [4:0] R_ANER   = 5'd6;

  // Register bits
  localparam logic [15:0] CTL_RESET   = 16'h8000;
  localparam logic [15:0] CTL_SPEED   = 16'h2000;
  localparam logic [15:0] CTL_RESTART = 16'h0200;
  localparam logic [15:0] CTL_DUPLEX  = 16'h0100;
  localparam logic [15:0] ST_LINK     = 16'h0004;
  localparam logic [15:0] ST_ANDONE   = 16'h0020;
  localparam logic [15:0] AD_CSMA     = 16'h0001;
  localparam logic [15:0] AD_10HD     = 16'h0020;
  localparam logic [15:0] AD_10FD     = 16'h0040;
  localparam logic [15:0] AD_100HD    = 16'h0080;
  localparam logic [15:0] AD_100FD    = 16'h0100;
  localparam logic [15:0] AD_PAUSE    = 16'h0400;
  localparam logic [15:0] AD_LPACK    = 16'h4000;

  // Defaults
  localparam logic [15:0] BMCR_DEF      = 16'h2100;
  localparam logic [15:0] BMSR_DEF      = 16'h7809;
  localparam logic [15:0] ANAR_DEF      = 16'h01E1;
  localparam logic [15:0] ANAR_DEF_PSE  = 16'h05E1;
  localparam logic [15:0] ZERO_DEF      = 16'h0000;
  localparam logic [15:0] DELAY_RST     = 16'd500;
  localparam logic [15:0] ID_HIGH_RST   = 16'h2000;
  localparam logic [15:0] ID_LOW_RST    = 16'h5C01;

  // Default contents of one register
  function automatic logic [15:0] reg_default(input logic [4:0] idx, input logic pause,
                                               input logic [15:0] id_hi,
                                               input logic [15:0] id_lo);
    logic [15:0] v;
    v = ZERO_DEF;
    case (idx)
      R_BMCR: v = BMCR_DEF;
      R_BMSR: v = BMSR_DEF;
      R_ID2:  v = id_hi;
      R_ID3:  v = id_lo;
      R_ANAR: v = pause ? ANAR_DEF_PSE : ANAR_DEF;
      default: v = ZERO_DEF;
    endcase
    return v;
  endfunction

  function automatic phy_result_t make_result(input logic [15:0] rd, input logic spd,
                                              input logic dup, input logic neg,
                                              input logic ntf);
    phy_result_t r;
    r.read_data   = rd;
    r.speed_100   = spd;
    r.duplex_full = dup;
    r.negotiated  = neg;
    r.link_notify = ntf;
    return r;
  endfunction

endpackage

/* rtl/mii_prf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mii_prf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mii_phy_register_file.sv */
// Top level of the Clause 22 MII PHY register file.
//
// Command channel: an item (read, write or timer tick) is taken at a rising
// edge with start high and busy low. Each item yields one result beat on
// result, marked by done for exactly one cycle; the receiver cannot stall.
// Configuration is written through the APB port (pause model, negotiation
// delay, PHY identifier defaults); the user must write it only while the
// block is idle, which the block itself does not enforce.
// Items that finish at once: ticks that do not finish negotiation, ordinary
// writes, out-of-range addresses and the unused command. Other items pass
// through sequencer states: in-range reads through S_RD (one RAM read), BMCR
// writes without restart through S_BMCR, BMCR writes with restart through
// S_BMCR then S_BMSR_CLR, the tick that finishes negotiation through S_ANAR
// then S_BMSR_SET, and a BMCR write with the reset bit through the reload
// sweep. busy rises only for those items and falls as done rises, so items
// run one at a time and the next may start in the done cycle.
// Reset: rst clears the control state and loads the reset configuration; a
// clearing pass over all REG_COUNT registers then loads the defaults into the
// RAM, with busy held high throughout. No result beat comes from that pass.
module mii_phy_register_file
  import mii_prf_pkg::*;
#(
  parameter int REG_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  phy_item_t   item,
  output logic        done,
  output phy_result_t result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(REG_COUNT);
  localparam logic [AW-1:0] LAST     = AW'(REG_COUNT - 1);
  localparam logic [AW-1:0] A_BMCR   = AW'(R_BMCR);
  localparam logic [AW-1:0] A_BMSR   = AW'(R_BMSR);
  localparam logic [AW-1:0] A_ANAR   = AW'(R_ANAR);
  localparam logic [AW-1:0] A_ANLPAR = AW'(R_ANLPAR);
  localparam logic [AW-1:0] A_ANER   = AW'(R_ANER);

  // sequencer states
  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_RD       = 3'd2;
  localparam logic [2:0] S_BMCR     = 3'd3;
  localparam logic [2:0] S_BMSR_CLR = 3'd4;
  localparam logic [2:0] S_ANAR     = 3'd5;
  localparam logic [2:0] S_BMSR_SET = 3'd6;
  localparam logic [2:0] S_SWEEP    = 3'd7;

  logic [2:0]    state, state_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          an_done, an_done_next;
  logic          spd, spd_next;
  logic          dup, dup_next;
  logic [15:0]   countdown, countdown_next;
  logic          notify_pend, notify_next;
  logic          done_next;
  phy_result_t   res_next;
  logic [AW-1:0] addr_q;
  logic [15:0]   data_q;

  logic          pause_model;
  logic [15:0]   an_delay;
  logic [15:0]   id_hi;
  logic [15:0]   id_lo;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          acc;
  logic          in_range;
  logic          cfg_wr;
  logic          lnk_change;
  logic [15:0]   partner;
  logic [15:0]   common;
  logic [15:0]   anar_v;

  assign busy     = (state != S_IDLE);
  assign acc      = start && !busy;
  assign in_range = ({1'b0, item.reg_addr} < 6'(REG_COUNT));
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // register storage
  mii_prf_ram #(
    .WIDTH (16),
    .DEPTH (REG_COUNT)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration read-back
  always_comb begin
    case (paddr[3:2])
      CFG_PAUSE: prdata = {31'd0, pause_model};
      CFG_DELAY: prdata = {16'd0, an_delay};
      CFG_IDHI:  prdata = {16'd0, id_hi};
      CFG_IDLO:  prdata = {16'd0, id_lo};
      default:   prdata = 32'd0;
    endcase
  end

  // sequencer: read, modify and write back the register RAM
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    an_done_next   = an_done;
    spd_next       = spd;
    dup_next       = dup;
    countdown_next = countdown;
    notify_next    = notify_pend;
    done_next      = 1'b0;
    res_next       = result;
    ram_we         = 1'b0;
    ram_waddr      = cnt;
    ram_wdata      = ZERO_DEF;
    ram_raddr      = addr_q;
    lnk_change     = 1'b0;
    partner        = AD_100FD | AD_100HD | AD_10FD | AD_10HD;
    if (pause_model) begin
      partner = partner | AD_PAUSE;
    end
    common = ram_rdata & partner;
    anar_v = item.write_data | AD_CSMA;
    if (!pause_model) begin
      anar_v = anar_v & ~AD_PAUSE;
    end

    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = reg_default(5'(cnt), 1'b0, ID_HIGH_RST, ID_LOW_RST);
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = reg_default(5'(cnt), pause_model, id_hi, id_lo);
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_IDLE;
          done_next  = 1'b1;
          res_next   = make_result(ZERO_DEF, spd, dup, an_done, 1'b0);
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      S_IDLE: begin
        if (acc) begin
          // immediate finish unless a branch below goes on
          done_next = 1'b1;
          res_next  = make_result(ZERO_DEF, spd, dup, an_done, 1'b0);
          case (item.cmd)
            CMD_READ: begin
              if (in_range) begin
                ram_raddr  = item.reg_addr[AW-1:0];
                done_next  = 1'b0;
                state_next = S_RD;
              end
            end
            CMD_WRITE: begin
              if (in_range) begin
                if (item.reg_addr[AW-1:0] == A_BMCR) begin
                  done_next = 1'b0;
                  if ((item.write_data & CTL_RESET) != ZERO_DEF) begin
                    cnt_next   = '0;
                    state_next = S_SWEEP;
                  end else begin
                    ram_raddr  = A_BMCR;
                    state_next = S_BMCR;
                  end
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = item.reg_addr[AW-1:0];
                  ram_wdata = (item.reg_addr[AW-1:0] == A_ANAR) ? anar_v
                                                                 : item.write_data;
                end
              end
            end
            CMD_TICK: begin
              if (countdown != 16'd0) begin
                countdown_next = countdown - 16'd1;
                if (countdown == 16'd1) begin
                  ram_raddr  = A_ANAR;
                  done_next  = 1'b0;
                  state_next = S_ANAR;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        // BMSR read re-asserts link, and AN-complete once negotiated; ANER always reads zero
        if (addr_q == A_BMSR) begin
          ram_we    = 1'b1;
          ram_waddr = A_BMSR;
          ram_wdata = ram_rdata | ST_LINK | (an_done ? ST_ANDONE : ZERO_DEF);
        end
        state_next = S_IDLE;
        done_next  = 1'b1;
        res_next   = make_result((addr_q == A_ANER) ? ZERO_DEF : ram_rdata,
                                 spd, dup, an_done, 1'b0);
      end

      S_BMCR: begin
        lnk_change = ((data_q ^ ram_rdata) & (CTL_SPEED | CTL_DUPLEX)) != ZERO_DEF;
        if (lnk_change) begin
          spd_next = (data_q & CTL_SPEED) != ZERO_DEF;
          dup_next = (data_q & CTL_DUPLEX) != ZERO_DEF;
        end
        ram_we    = 1'b1;
        ram_waddr = A_BMCR;
        ram_wdata = data_q & ~(CTL_RESTART | CTL_RESET);
        if ((data_q & CTL_RESTART) != ZERO_DEF) begin
          an_done_next   = 1'b0;
          countdown_next = (an_delay == 16'd0) ? 16'd1 : an_delay;
          notify_next    = lnk_change;
          ram_raddr      = A_BMSR;
          state_next     = S_BMSR_CLR;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          res_next   = make_result(ZERO_DEF, spd_next, dup_next, an_done, lnk_change);
        end
      end

      S_BMSR_CLR: begin
        ram_we     = 1'b1;
        ram_waddr  = A_BMSR;
        ram_wdata  = ram_rdata & ~ST_ANDONE;
        state_next = S_IDLE;
        done_next  = 1'b1;
        res_next   = make_result(ZERO_DEF, spd, dup, an_done, notify_pend);
      end

      S_ANAR: begin
        // negotiation done: partner abilities and best common mode
        ram_we    = 1'b1;
        ram_waddr = A_ANLPAR;
        ram_wdata = partner | AD_LPACK;
        if ((common & AD_100FD) != ZERO_DEF) begin
          spd_next = 1'b1;
          dup_next = 1'b1;
        end else if ((common & AD_100HD) != ZERO_DEF) begin
          spd_next = 1'b1;
          dup_next = 1'b0;
        end else if ((common & AD_10FD) != ZERO_DEF) begin
          spd_next = 1'b0;
          dup_next = 1'b1;
        end else begin
          spd_next = 1'b0;
          dup_next = 1'b0;
        end
        an_done_next = 1'b1;
        ram_raddr    = A_BMSR;
        state_next   = S_BMSR_SET;
      end

      S_BMSR_SET: begin
        ram_we     = 1'b1;
        ram_waddr  = A_BMSR;
        ram_wdata  = ram_rdata | ST_ANDONE;
        state_next = S_IDLE;
        done_next  = 1'b1;
        res_next   = make_result(ZERO_DEF, spd, dup, an_done, 1'b1);
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cnt         <= '0;
      an_done     <= 1'b0;
      spd         <= 1'b0;
      dup         <= 1'b0;
      countdown   <= 16'd0;
      notify_pend <= 1'b0;
      done        <= 1'b0;
      pause_model <= 1'b0;
      an_delay    <= DELAY_RST;
      id_hi       <= ID_HIGH_RST;
      id_lo       <= ID_LOW_RST;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      an_done     <= an_done_next;
      spd         <= spd_next;
      dup         <= dup_next;
      countdown   <= countdown_next;
      notify_pend <= notify_next;
      done        <= done_next;
      if (cfg_wr) begin
        case (paddr[3:2])
          CFG_PAUSE: pause_model <= pwdata[0];
          CFG_DELAY: an_delay    <= pwdata[15:0];
          CFG_IDHI:  id_hi       <= pwdata[15:0];
          CFG_IDLO:  id_lo       <= pwdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= res_next;
    if (acc) begin
      addr_q <= item.reg_addr[AW-1:0];
      data_q <= item.write_data;
    end
  end

endmodule

/* rtl/mii_prf_checker.sv */
// Port-level checks for the MII PHY register file, bound to the top level.
module mii_prf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // reset always starts the clearing pass
  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // an accepted item either finishes at once or keeps the block busy
  a_acc_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither busy nor done");

  // a result beat leaves the block free for the next item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // no result beat without work before it
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result beat without an item");

endmodule

bind mii_phy_register_file mii_prf_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

/* tb/mii_phy_register_file_tb.sv */
// Self-checking testbench for the Clause 22 MII PHY register file.
`timescale 1ns / 100ps

module mii_phy_register_file_tb;
  import mii_prf_pkg::*;

  // Clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  phy_item_t   item = '0;
  logic        done;
  phy_result_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Commands waiting to be driven, and results still owed by the block
  phy_item_t   cmd_backlog[$];
  phy_result_t awaited_results[$];
  int unsigned sender_idle_pct = 0;
  int unsigned mismatch_count = 0;

  // Shadow copy of the PHY: register array, link state and configuration
  logic [15:0] mirror_regs[32];
  logic        mirror_an_done;
  logic        mirror_spd;
  logic        mirror_fdx;
  logic [15:0] mirror_countdown;
  logic        cfg_pause;
  logic [15:0] cfg_delay;
  logic [15:0] cfg_id_hi;
  logic [15:0] cfg_id_lo;

  mii_phy_register_file dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Default register contents from the current configuration
  function automatic void reload_phy_defaults();
    for (int i = 0; i < 32; i++) mirror_regs[i] = ZERO_DEF;
    mirror_regs[R_BMCR] = BMCR_DEF;
    mirror_regs[R_BMSR] = BMSR_DEF;
    mirror_regs[R_ID2]  = cfg_id_hi;
    mirror_regs[R_ID3]  = cfg_id_lo;
    mirror_regs[R_ANAR] = cfg_pause ? ANAR_DEF_PSE : ANAR_DEF;
  endfunction

  // Apply one command to the shadow PHY and return the beat it should give
  function automatic phy_result_t phy_file_step(input phy_item_t it);
    logic [15:0] rd;
    logic [15:0] old;
    logic [15:0] v;
    logic [15:0] partner;
    logic [15:0] common;
    logic        ntf;
    phy_result_t r;
    rd  = 16'h0000;
    ntf = 1'b0;
    case (it.cmd)
      CMD_READ: begin
        rd = mirror_regs[it.reg_addr];
        if (it.reg_addr == R_BMSR) begin
          // reading status re-asserts link, and AN-complete once negotiated
          mirror_regs[R_BMSR] |= ST_LINK;
          if (mirror_an_done) mirror_regs[R_BMSR] |= ST_ANDONE;
        end else if (it.reg_addr == R_ANER) begin
          rd = 16'h0000;
        end
      end
      CMD_WRITE: begin
        old = mirror_regs[it.reg_addr];
        v   = it.write_data;
        if (it.reg_addr == R_BMCR) begin
          if (|(v & CTL_RESET)) begin
            // reset bit reloads registers only; link and countdown are kept
            reload_phy_defaults();
          end else begin
            if (|(v & CTL_RESTART)) begin
              mirror_an_done = 1'b0;
              mirror_regs[R_BMSR] &= ~ST_ANDONE;
              mirror_countdown = (cfg_delay == 16'd0) ? 16'd1 : cfg_delay;
            end
            if (|((v ^ old) & (CTL_SPEED | CTL_DUPLEX))) begin
              mirror_spd = |(v & CTL_SPEED);
              mirror_fdx = |(v & CTL_DUPLEX);
              ntf = 1'b1;
            end
            mirror_regs[R_BMCR] = v & ~(CTL_RESTART | CTL_RESET);
          end
        end else if (it.reg_addr == R_ANAR) begin
          v |= AD_CSMA;
          if (!cfg_pause) v &= ~AD_PAUSE;
          mirror_regs[R_ANAR] = v;
        end else begin
          mirror_regs[it.reg_addr] = v;
        end
      end
      CMD_TICK: begin
        if (mirror_countdown != 16'd0) begin
          mirror_countdown = mirror_countdown - 16'd1;
          if (mirror_countdown == 16'd0) begin
            // negotiation done: partner page, then best common mode
            partner = AD_100FD | AD_100HD | AD_10FD | AD_10HD;
            if (cfg_pause) partner |= AD_PAUSE;
            mirror_regs[R_ANLPAR] = partner | AD_LPACK;
            mirror_an_done = 1'b1;
            mirror_regs[R_BMSR] |= ST_ANDONE;
            common = mirror_regs[R_ANAR] & partner;
            if (|(common & AD_100FD)) begin
              mirror_spd = 1'b1; mirror_fdx = 1'b1;
            end else if (|(common & AD_100HD)) begin
              mirror_spd = 1'b1; mirror_fdx = 1'b0;
            end else if (|(common & AD_10FD)) begin
              mirror_spd = 1'b0; mirror_fdx = 1'b1;
            end else begin
              mirror_spd = 1'b0; mirror_fdx = 1'b0;
            end
            ntf = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.read_data   = rd;
    r.speed_100   = mirror_spd;
    r.duplex_full = mirror_fdx;
    r.negotiated  = mirror_an_done;
    r.link_notify = ntf;
    return r;
  endfunction

  function automatic phy_item_t mk_cmd(input logic [1:0] c, input logic [4:0] a,
                                       input logic [15:0] d);
    phy_item_t it;
    it.cmd        = c;
    it.reg_addr   = a;
    it.write_data = d;
    return it;
  endfunction

  // Mostly reads, ticks and control writes; some stray addresses and junk
  function automatic phy_item_t random_cmd();
    int unsigned pick;
    logic [4:0]  a;
    logic [15:0] d;
    pick = $urandom_range(99);
    d    = 16'($urandom_range(16'hFFFF));
    if (pick < 38) begin
      a = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(6));
      return mk_cmd(CMD_READ, a, d);
    end else if (pick < 62) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // keep reset rare: it costs a full reload sweep
        if ($urandom_range(19) != 0) d &= ~CTL_RESET;
        a = R_BMCR;
      end else if (pick < 65) begin
        a = R_ANAR;
      end else begin
        a = 5'($urandom_range(31));
        if (a == R_BMCR && $urandom_range(19) != 0) d &= ~CTL_RESET;
      end
      return mk_cmd(CMD_WRITE, a, d);
    end else if (pick < 97) begin
      return mk_cmd(CMD_TICK, 5'($urandom_range(31)), d);
    end
    return mk_cmd(CMD_UNUSED, 5'($urandom_range(31)), d);
  endfunction

  // Command driver: holds start until accepted, predicts on acceptance
  always @(posedge clk) begin : cmd_drive
    logic      accepted;
    phy_item_t nxt;
    accepted = start && !busy;
    if (accepted) awaited_results.push_back(phy_file_step(item));
    if (!start || accepted) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        item  <= nxt;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: every done beat against the oldest expectation
  always @(posedge clk) begin : res_check
    phy_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result beat rd=%h spd=%b fdx=%b neg=%b ntf=%b",
                   $realtime, result.read_data, result.speed_100, result.duplex_full,
                   result.negotiated, result.link_notify);
      end else begin
        want = awaited_results.pop_front();
        if (result.read_data !== want.read_data || result.speed_100 !== want.speed_100 ||
            result.duplex_full !== want.duplex_full || result.negotiated !== want.negotiated ||
            result.link_notify !== want.link_notify) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch exp rd=%h spd=%b fdx=%b neg=%b ntf=%b",
                     $realtime, want.read_data, want.speed_100, want.duplex_full,
                     want.negotiated, want.link_notify);
            $display("%0t:          got rd=%h spd=%b fdx=%b neg=%b ntf=%b",
                     $realtime, result.read_data, result.speed_100,
                     result.duplex_full, result.negotiated, result.link_notify);
          end
        end
      end
    end
  end

  // APB write: setup then access; the shadow config follows
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CFG_PAUSE: cfg_pause = val[0];
      CFG_DELAY: cfg_delay = val;
      CFG_IDHI:  cfg_id_hi = val;
      default:   cfg_id_lo = val;
    endcase
  endtask

  task automatic set_config(input logic pse, input logic [15:0] dly,
                            input logic [15:0] hi, input logic [15:0] lo);
    cfg_write(CFG_PAUSE, {15'd0, pse});
    cfg_write(CFG_DELAY, dly);
    cfg_write(CFG_IDHI, hi);
    cfg_write(CFG_IDLO, lo);
  endtask

  // Wait until every command is driven, answered and the block is idle;
  // sampled mid-cycle so the edge updates have all settled
  task automatic drain();
    while (cmd_backlog.size() != 0 || start || awaited_results.size() != 0 || busy)
      @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int unsigned idle);
    sender_idle_pct = idle;
    repeat (n) cmd_backlog.push_back(random_cmd());
    drain();
  endtask

  // Stimulus
  initial begin
    cfg_pause = 1'b0;
    cfg_delay = DELAY_RST;
    cfg_id_hi = ID_HIGH_RST;
    cfg_id_lo = ID_LOW_RST;
    reload_phy_defaults();
    mirror_an_done   = 1'b0;
    mirror_spd       = 1'b0;
    mirror_fdx       = 1'b0;
    mirror_countdown = 16'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // directed: defaults, masking on ANAR/ANER, speed/duplex, reload, idle ticks
    for (int i = 0; i <= 6; i++) cmd_backlog.push_back(mk_cmd(CMD_READ, 5'(i), 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_BMSR, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_ANAR, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_ANAR, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_ANER, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_ANER, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_BMCR, 16'h0100));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_BMCR, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_BMCR, CTL_RESET));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_ANAR, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_UNUSED, 5'd31, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(CMD_TICK, 5'd0, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, 5'd31, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_READ, 5'd31, 16'h0000));
    drain();

    // directed: pause model, zero delay, extreme IDs, one-tick negotiation
    set_config(1'b1, 16'd0, 16'hFFFF, 16'h0000);
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_BMCR, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_ID2, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_BMCR, 16'h1200));
    cmd_backlog.push_back(mk_cmd(CMD_TICK, 5'd0, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_BMSR, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_ANLPAR, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_BMSR, 16'h0000));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, R_ANAR, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(CMD_READ, R_ANAR, 16'h0000));
    drain();

    // random phases over several settings
    set_config(1'b0, 16'($urandom_range(1, 6)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)));
    random_phase(650, 16);
    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    random_phase(120, 84);
    set_config(1'b1, 16'($urandom_range(1, 12)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)));
    random_phase(450, 84);
    set_config(1'b0, 16'd0, 16'h0000, 16'hFFFF);
    random_phase(480, 0);

    // allow for a late reload sweep before deciding
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("[mii_phy_register_file] OK");
    else
      $display("[mii_phy_register_file] ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("[mii_phy_register_file] ERROR");
    $finish;
  end

endmodule
